FILE: hdl/rcns_pkg.sv
// shared types, constants and tables for the rotary carousel nearest-slot block
package rcns_pkg;

    localparam int NUM_SLOTS = 18;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SPT_W     = 12;
    localparam int STEPS_W   = 17;
    localparam int CODE_W    = 4;
    localparam int VAL_W     = 5;
    localparam int STEP_W    = 4;

    localparam logic [SPT_W-1:0]  SPT_RESET  = 12'd688;
    localparam logic [CODE_W-1:0] EMPTY_CODE = 4'd15;
    localparam logic [CODE_W-1:0] MAX_DIGIT  = 4'd9;
    localparam logic signed [VAL_W-1:0] VAL_MIN   = -5'sd1;
    localparam logic signed [VAL_W-1:0] VAL_MAX   = 5'sd9;
    localparam logic signed [VAL_W-1:0] PRES_MOVE = -5'sd2;
    localparam logic signed [VAL_W-1:0] PRES_EMPTY = -5'sd1;

    // request codes
    localparam logic [2:0] REQ_SEEK  = 3'd0;
    localparam logic [2:0] REQ_WRITE = 3'd1;
    localparam logic [2:0] REQ_TICK  = 3'd2;
    localparam logic [2:0] REQ_NEXT  = 3'd3;
    localparam logic [2:0] REQ_PREV  = 3'd4;

    // microprogram step addresses
    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_PREP   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_CHK_WR = 4'd2;
    localparam logic [STEP_W-1:0] STEP_CHK_TK = 4'd3;
    localparam logic [STEP_W-1:0] STEP_CHK_MV = 4'd4;
    localparam logic [STEP_W-1:0] STEP_REJECT = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SCAN   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_PICK   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_START  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_WRITE  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_TICK   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_NEIGH  = 4'd11;
    localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd12;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_PREP,
        OP_SCAN,
        OP_PICK,
        OP_START,
        OP_WRITE,
        OP_TICK,
        OP_NEIGH,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_INPUT,
        C_SEEK_OK,
        C_WRITE_OK,
        C_TICK,
        C_MOVE_OK,
        C_SCAN_MORE,
        C_NO_MATCH,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
        logic              last;
    } t_uword;

    typedef struct packed {
        logic seek_ok;
        logic write_ok;
        logic tick;
        logic move_ok;
        logic scan_more;
        logic no_match;
        logic out_busy;
    } t_status;

    // tray contents after reset
    function automatic logic [CODE_W-1:0] layout_code(input logic [SLOT_W-1:0] idx);
        logic [CODE_W-1:0] code;
        case (5'(idx))
            5'd0, 5'd1:        code = 4'd0;
            5'd2, 5'd3, 5'd4:  code = 4'd1;
            5'd5, 5'd6:        code = 4'd2;
            5'd7, 5'd8:        code = 4'd3;
            5'd9, 5'd10:       code = 4'd4;
            5'd11, 5'd12, 5'd13: code = 4'd5;
            5'd14:             code = 4'd6;
            5'd15:             code = 4'd7;
            5'd16:             code = 4'd8;
            5'd17:             code = 4'd9;
            default:           code = EMPTY_CODE;
        endcase
        return code;
    endfunction

endpackage

FILE: hdl/rcns_useq.sv
// microprogram rom, step counter and branch logic
module rcns_useq import rcns_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_op     o_op
);

    logic [STEP_W-1:0] r_upc;
    logic [STEP_W-1:0] n_upc;
    t_uword            uw;
    logic              take;

    function automatic t_uword rom(input logic [STEP_W-1:0] a);
        t_uword w;
        case (a)
            STEP_IDLE:   w = '{OP_LATCH, C_NO_INPUT,  STEP_IDLE,   1'b0};
            STEP_PREP:   w = '{OP_PREP,  C_SEEK_OK,   STEP_SCAN,   1'b0};
            STEP_CHK_WR: w = '{OP_NOP,   C_WRITE_OK,  STEP_WRITE,  1'b0};
            STEP_CHK_TK: w = '{OP_NOP,   C_TICK,      STEP_TICK,   1'b0};
            STEP_CHK_MV: w = '{OP_NOP,   C_MOVE_OK,   STEP_NEIGH,  1'b0};
            STEP_REJECT: w = '{OP_NOP,   C_ALWAYS,    STEP_EMIT,   1'b0};
            STEP_SCAN:   w = '{OP_SCAN,  C_SCAN_MORE, STEP_SCAN,   1'b0};
            STEP_PICK:   w = '{OP_PICK,  C_NO_MATCH,  STEP_EMIT,   1'b0};
            STEP_START:  w = '{OP_START, C_ALWAYS,    STEP_EMIT,   1'b0};
            STEP_WRITE:  w = '{OP_WRITE, C_ALWAYS,    STEP_EMIT,   1'b0};
            STEP_TICK:   w = '{OP_TICK,  C_ALWAYS,    STEP_EMIT,   1'b0};
            STEP_NEIGH:  w = '{OP_NEIGH, C_ALWAYS,    STEP_START,  1'b0};
            STEP_EMIT:   w = '{OP_EMIT,  C_OUT_BUSY,  STEP_EMIT,   1'b1};
            default:     w = '{OP_NOP,   C_ALWAYS,    STEP_IDLE,   1'b0};
        endcase
        return w;
    endfunction

    always_comb begin
        uw = rom(r_upc);
        case (uw.cond)
            C_ALWAYS:    take = 1'b1;
            C_NO_INPUT:  take = !i_in_valid;
            C_SEEK_OK:   take = i_status.seek_ok;
            C_WRITE_OK:  take = i_status.write_ok;
            C_TICK:      take = i_status.tick;
            C_MOVE_OK:   take = i_status.move_ok;
            C_SCAN_MORE: take = i_status.scan_more;
            C_NO_MATCH:  take = i_status.no_match;
            C_OUT_BUSY:  take = i_status.out_busy;
            default:     take = 1'b0;
        endcase
        if (take) begin
            n_upc = uw.target;
        end else if (uw.last) begin
            n_upc = STEP_IDLE;
        end else begin
            n_upc = r_upc + 1'b1;
        end
        o_op = uw.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= STEP_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

FILE: hdl/rcns_dpath.sv
// datapath: tray store, scan unit, move registers and output register
module rcns_dpath import rcns_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_op                 i_op,
    output t_status             o_status,
    input  logic                i_in_valid,
    input  logic [2:0]          i_req_type,
    input  logic [VAL_W-1:0]    i_digit_value,
    input  logic [SPT_W-1:0]    i_spt,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_accepted,
    output logic [VAL_W-1:0]    o_presented,
    output logic                o_busy_res,
    output logic                o_move_clockwise,
    output logic [STEPS_W-1:0]  o_move_steps,
    output logic [4:0]          o_target_slot,
    output logic                o_move_done
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    logic [CODE_W-1:0]  r_slot [NUM_SLOTS];
    logic [2:0]         r_req;
    logic [VAL_W-1:0]   r_val;
    logic [SLOT_W-1:0]  r_cur, r_goal, r_ptr, r_cnt, r_first, r_last, r_trays;
    logic               r_moving, r_found, r_dir, r_acc, r_done;
    logic [STEPS_W-1:0] r_rem, r_msteps;

    logic               r_out_valid, r_o_acc, r_o_busy, r_o_cw, r_o_done;
    logic [VAL_W-1:0]   r_o_pres;
    logic [STEPS_W-1:0] r_o_steps;
    logic [SLOT_W-1:0]  r_o_goal;

    logic [SLOT_W-1:0]        rd_addr, ccw_dist;
    logic [CODE_W-1:0]        rd_code, want;
    logic                     val_ok, hit, cw_wins, load_out;
    logic [SLOT_W+SPT_W-1:0]  prod;
    logic [STEPS_W-1:0]       rem_dec;
    logic [SLOT_W:0]          ccw_wide;
    logic [VAL_W-1:0]         pres;

    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SLOT_W+1)'(NUM_SLOTS)) begin
            s = s - (SLOT_W+1)'(NUM_SLOTS);
        end
        return s[SLOT_W-1:0];
    endfunction

    // single read port: scan pointer while scanning, current tray otherwise
    always_comb begin
        rd_addr  = (i_op == OP_SCAN) ? r_ptr : r_cur;
        rd_code  = r_slot[rd_addr];
        want     = r_val[VAL_W-1] ? EMPTY_CODE : r_val[CODE_W-1:0];
        val_ok   = ($signed(r_val) >= VAL_MIN) && ($signed(r_val) <= VAL_MAX);
        hit      = (rd_code == want);
        ccw_wide = (SLOT_W+1)'(NUM_SLOTS) - {1'b0, r_last};
        ccw_dist = (r_first == '0) ? '0 : ccw_wide[SLOT_W-1:0];
        cw_wins  = (r_first <= ccw_dist);
        prod     = r_trays * i_spt;
        rem_dec  = (r_rem == '0) ? '0 : r_rem - 1'b1;
        load_out = (i_op == OP_EMIT) && (!r_out_valid || i_out_ready);
        if (r_moving) begin
            pres = PRES_MOVE;
        end else if (rd_code > MAX_DIGIT) begin
            pres = PRES_EMPTY;
        end else begin
            pres = VAL_W'(rd_code);
        end
        o_status.seek_ok   = (r_req == REQ_SEEK) && !r_moving && val_ok;
        o_status.write_ok  = (r_req == REQ_WRITE) && !r_moving && val_ok;
        o_status.tick      = (r_req == REQ_TICK);
        o_status.move_ok   = ((r_req == REQ_NEXT) || (r_req == REQ_PREV)) && !r_moving;
        o_status.scan_more = (r_cnt != LAST_SLOT);
        o_status.no_match  = !r_found;
        o_status.out_busy  = r_out_valid && !i_out_ready;
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot[i] <= layout_code(SLOT_W'(i));
            end
            r_cur    <= '0;
            r_goal   <= '0;
            r_moving <= 1'b0;
            r_rem    <= '0;
        end else begin
            case (i_op)
                OP_PICK: begin
                    if (r_found) begin
                        r_goal <= cw_wins ? slot_add(r_cur, r_first)
                                          : slot_add(r_cur, r_last);
                    end
                end
                OP_NEIGH: begin
                    if (r_req == REQ_NEXT) begin
                        r_goal <= (r_cur == LAST_SLOT) ? '0 : r_cur + 1'b1;
                    end else begin
                        r_goal <= (r_cur == '0) ? LAST_SLOT : r_cur - 1'b1;
                    end
                end
                OP_START: begin
                    r_rem    <= STEPS_W'(prod);
                    r_moving <= 1'b1;
                end
                OP_WRITE: begin
                    r_slot[r_cur] <= want;
                end
                OP_TICK: begin
                    if (r_moving) begin
                        r_rem <= rem_dec;
                        if (rem_dec == '0) begin
                            r_cur    <= r_goal;
                            r_moving <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LATCH: begin
                if (i_in_valid) begin
                    r_req <= i_req_type;
                    r_val <= i_digit_value;
                end
            end
            OP_PREP: begin
                r_acc    <= 1'b0;
                r_dir    <= 1'b0;
                r_msteps <= '0;
                r_done   <= 1'b0;
                r_ptr    <= r_cur;
                r_cnt    <= '0;
                r_found  <= 1'b0;
            end
            OP_SCAN: begin
                if (hit) begin
                    if (!r_found) begin
                        r_first <= r_cnt;
                    end
                    r_last  <= r_cnt;
                    r_found <= 1'b1;
                end
                r_ptr <= (r_ptr == LAST_SLOT) ? '0 : r_ptr + 1'b1;
                r_cnt <= r_cnt + 1'b1;
            end
            OP_PICK: begin
                r_dir   <= r_found && cw_wins;
                r_trays <= cw_wins ? r_first : ccw_dist;
            end
            OP_NEIGH: begin
                r_dir   <= (r_req == REQ_NEXT);
                r_trays <= SLOT_W'(1);
            end
            OP_START: begin
                r_msteps <= STEPS_W'(prod);
                r_acc    <= 1'b1;
            end
            OP_WRITE: begin
                r_acc <= 1'b1;
            end
            OP_TICK: begin
                r_done <= r_moving && (rem_dec == '0);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_acc   <= r_acc;
            r_o_pres  <= pres;
            r_o_busy  <= r_moving;
            r_o_cw    <= r_dir;
            r_o_steps <= r_msteps;
            r_o_goal  <= r_goal;
            r_o_done  <= r_done;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_o_acc;
    assign o_presented      = r_o_pres;
    assign o_busy_res       = r_o_busy;
    assign o_move_clockwise = r_o_cw;
    assign o_move_steps     = r_o_steps;
    assign o_target_slot    = 5'(r_o_goal);
    assign o_move_done      = r_o_done;

endmodule

FILE: hdl/rotary_carousel_nearest_slot.sv
// top level of the rotary carousel nearest-slot controller
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+--------------------------------
//  input     | in        | i_in_valid / o_in_ready   | i_req_type, i_digit_value
//  result    | out       | o_out_valid / i_out_ready | o_accepted .. o_move_done
//  config    | in        | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// one transaction at a time; the microprogram decides the length, fetch to fetch
// digit request: fetch, setup, one read of each of the 18 trays, pick, multiply,
//   emit; the multiply step is skipped when no tray matches
// write, tick, other rejected commands, then next and previous, each run more steps
// the tray scan goes through the single read port of the tray store
// synchronous active-low reset restores the tray layout, tray 0 and 688 steps
// the result sits in an output register, so a new input transaction is taken
//   while the previous result waits for i_out_ready
// a stalled output holds the sequencer in its emit step until the register frees
module rotary_carousel_nearest_slot import rcns_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_req_type,
    input  logic [VAL_W-1:0]   i_digit_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_accepted,
    output logic [VAL_W-1:0]   o_presented,
    output logic               o_busy_res,
    output logic               o_move_clockwise,
    output logic [STEPS_W-1:0] o_move_steps,
    output logic [4:0]         o_target_slot,
    output logic               o_move_done,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic ADDR_SPT = 1'b0;   // word index of the tray step count

    logic [SPT_W-1:0] r_spt;
    logic             cfg_wr;
    t_op              op;
    t_status          status;

    // register write lands on the access phase; pready is tied high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ADDR_SPT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt <= SPT_RESET;
        end else if (cfg_wr) begin
            r_spt <= pwdata[SPT_W-1:0];
        end
    end

    // reads outside the register list return zero
    assign prdata = (paddr[2] == ADDR_SPT) ? {{(32-SPT_W){1'b0}}, r_spt} : 32'd0;

    // input is taken only in the fetch step of the microprogram, never in reset
    assign o_in_ready = i_rst_n && (op == OP_LATCH);

    rcns_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_op       (op)
    );

    rcns_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .o_status         (status),
        .i_in_valid       (i_in_valid),
        .i_req_type       (i_req_type),
        .i_digit_value    (i_digit_value),
        .i_spt            (r_spt),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_accepted       (o_accepted),
        .o_presented      (o_presented),
        .o_busy_res       (o_busy_res),
        .o_move_clockwise (o_move_clockwise),
        .o_move_steps     (o_move_steps),
        .o_target_slot    (o_target_slot),
        .o_move_done      (o_move_done)
    );

endmodule

FILE: hdl/rcns_chk.sv
// port-level checker for the carousel controller and its bind
module rcns_chk import rcns_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_accepted,
    input logic [VAL_W-1:0]   o_presented,
    input logic               o_busy_res,
    input logic               o_move_clockwise,
    input logic [STEPS_W-1:0] o_move_steps,
    input logic [4:0]         o_target_slot,
    input logic               o_move_done
);

    // presented shows the moving code exactly while busy
    a_pres_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_presented == PRES_MOVE) == o_busy_res))
        else $error("presented code disagrees with busy");

    // a completed move leaves the carousel at rest
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_move_done) |-> (!o_busy_res && !o_accepted))
        else $error("move done while still busy or accepted");

    // a rejected transaction starts no move
    a_reject_nomove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_accepted) |-> (o_move_steps == '0 && !o_move_clockwise))
        else $error("move reported on a rejected transaction");

    // target tray stays inside the carousel
    a_goal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_target_slot < 5'(NUM_SLOTS)))
        else $error("target tray out of range");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_presented)
            && $stable(o_move_steps) && $stable(o_target_slot)))
        else $error("stalled result changed");

endmodule

bind rotary_carousel_nearest_slot rcns_chk u_rcns_chk (.*);

FILE: sim/carousel_check_pkg.sv
// carousel state predictor and result scoreboard for the testbench
`timescale 1ns / 1ps

package carousel_check_pkg;

    import rcns_pkg::*;

    typedef struct packed {
        logic               accepted;
        logic [VAL_W-1:0]   presented;
        logic               busy;
        logic               clockwise;
        logic [STEPS_W-1:0] steps;
        logic [4:0]         target;
        logic               done;
    } t_carousel_result;

    class carousel_scoreboard;

        logic [CODE_W-1:0]  tray_code [NUM_SLOTS];
        int unsigned        cur_tray;
        int unsigned        goal_tray;
        int unsigned        steps_left;
        bit                 in_motion;
        logic [SPT_W-1:0]   spt;
        t_carousel_result   pending_results [$];
        int                 errors;

        function new();
            tray_code = '{4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3,
                          4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9};
            cur_tray   = 0;
            goal_tray  = 0;
            steps_left = 0;
            in_motion  = 0;
            spt        = 12'd688;
            errors     = 0;
        endfunction

        // arm a move and return its step count
        function logic [STEPS_W-1:0] launch(int unsigned trays, int unsigned goal);
            logic [STEPS_W-1:0] steps;
            steps      = STEPS_W'(trays * spt);
            goal_tray  = goal;
            steps_left = steps;
            in_motion  = 1;
            return steps;
        endfunction

        function void note_request(logic [2:0] req, logic signed [VAL_W-1:0] val);
            t_carousel_result exp;
            int               cw_dist;
            int               ccw_dist;
            int               i;
            bit               in_range;
            logic [CODE_W-1:0] want;
            exp      = '0;
            in_range = (val >= -1) && (val <= 9);
            want     = (val < 0) ? EMPTY_CODE : val[CODE_W-1:0];
            case (req)
                REQ_SEEK: begin
                    if (!in_motion && in_range) begin
                        cw_dist  = -1;
                        ccw_dist = -1;
                        for (i = 0; i < NUM_SLOTS; i++)
                            if (cw_dist < 0 && tray_code[(cur_tray + i) % NUM_SLOTS] == want)
                                cw_dist = i;
                        for (i = 0; i < NUM_SLOTS; i++)
                            if (ccw_dist < 0 &&
                                tray_code[(cur_tray + NUM_SLOTS - i) % NUM_SLOTS] == want)
                                ccw_dist = i;
                        if (cw_dist >= 0 && ccw_dist >= 0) begin
                            exp.accepted = 1;
                            if (cw_dist <= ccw_dist) begin
                                exp.clockwise = 1;
                                exp.steps = launch(cw_dist, (cur_tray + cw_dist) % NUM_SLOTS);
                            end else begin
                                exp.steps = launch(ccw_dist,
                                    (cur_tray + NUM_SLOTS - ccw_dist) % NUM_SLOTS);
                            end
                        end
                    end
                end
                REQ_WRITE: begin
                    if (!in_motion && in_range) begin
                        tray_code[cur_tray] = want;
                        exp.accepted = 1;
                    end
                end
                REQ_TICK: begin
                    if (in_motion) begin
                        if (steps_left > 0)
                            steps_left--;
                        if (steps_left == 0) begin
                            cur_tray  = goal_tray;
                            in_motion = 0;
                            exp.done  = 1;
                        end
                    end
                end
                REQ_NEXT: begin
                    if (!in_motion) begin
                        exp.accepted  = 1;
                        exp.clockwise = 1;
                        exp.steps = launch(1, (cur_tray + 1) % NUM_SLOTS);
                    end
                end
                REQ_PREV: begin
                    if (!in_motion) begin
                        exp.accepted = 1;
                        exp.steps = launch(1, (cur_tray + NUM_SLOTS - 1) % NUM_SLOTS);
                    end
                end
                default: ;
            endcase
            if (in_motion)
                exp.presented = PRES_MOVE;
            else if (tray_code[cur_tray] > MAX_DIGIT)
                exp.presented = PRES_EMPTY;
            else
                exp.presented = {1'b0, tray_code[cur_tray]};
            exp.busy   = in_motion;
            exp.target = 5'(goal_tray);
            pending_results.push_back(exp);
        endfunction

        function void check_result(t_carousel_result got);
            t_carousel_result exp;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: %p", got);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.accepted !== exp.accepted) begin
                $error("accepted: expected %0d, got %0d", exp.accepted, got.accepted);
                errors++;
            end
            if (got.presented !== exp.presented) begin
                $error("presented: expected %0d, got %0d",
                       $signed(exp.presented), $signed(got.presented));
                errors++;
            end
            if (got.busy !== exp.busy) begin
                $error("busy_res: expected %0d, got %0d", exp.busy, got.busy);
                errors++;
            end
            if (got.clockwise !== exp.clockwise) begin
                $error("move_clockwise: expected %0d, got %0d", exp.clockwise, got.clockwise);
                errors++;
            end
            if (got.steps !== exp.steps) begin
                $error("move_steps: expected %0d, got %0d", exp.steps, got.steps);
                errors++;
            end
            if (got.target !== exp.target) begin
                $error("target_slot: expected %0d, got %0d", exp.target, got.target);
                errors++;
            end
            if (got.done !== exp.done) begin
                $error("move_done: expected %0d, got %0d", exp.done, got.done);
                errors++;
            end
        endfunction

    endclass

endpackage

FILE: sim/testbench.sv
// top-level testbench for the rotary carousel nearest-slot controller
`timescale 1ns / 1ps

module testbench;

    import rcns_pkg::*;
    import carousel_check_pkg::*;

    // byte address of the tray step count register
    localparam logic [2:0] ADDR_TRAY_STEPS = 3'd0;
    // quiet cycles after the last result, well past a full tray scan
    localparam int SETTLE_CYCLES = 2 * NUM_SLOTS + 12;
    // random requests per idling phase
    localparam int PHASE_REQUESTS = 260;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_req_type;
    logic [VAL_W-1:0]   i_digit_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_accepted;
    logic [VAL_W-1:0]   o_presented;
    logic               o_busy_res;
    logic               o_move_clockwise;
    logic [STEPS_W-1:0] o_move_steps;
    logic [4:0]         o_target_slot;
    logic               o_move_done;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // percentage of cycles in which each side holds off
    int send_hold_pct;
    int recv_hold_pct;

    carousel_scoreboard carousel = new();

    rotary_carousel_nearest_slot uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_digit_value    (i_digit_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_accepted       (o_accepted),
        .o_presented      (o_presented),
        .o_busy_res       (o_busy_res),
        .o_move_clockwise (o_move_clockwise),
        .o_move_steps     (o_move_steps),
        .o_target_slot    (o_target_slot),
        .o_move_done      (o_move_done),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs or drops a result
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // result side: sample just after the edge, so values are the ones the edge saw
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                carousel.check_result({o_accepted, o_presented, o_busy_res, o_move_clockwise,
                                       o_move_steps, o_target_slot, o_move_done});
            i_out_ready <= ($urandom_range(0, 99) >= recv_hold_pct);
        end
    end

    // offer one transaction; valid is only dropped when a gap is taken,
    // so back-to-back transactions keep it high across the edge
    task automatic send_request(input logic [2:0] req, input logic signed [VAL_W-1:0] val);
        while ($urandom_range(0, 99) < send_hold_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_digit_value <= val;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        carousel.note_request(req, val);
    endtask

    // tick until the predicted move has finished
    task automatic finish_move();
        while (carousel.in_motion)
            send_request(REQ_TICK, VAL_W'($urandom));
    endtask

    // let every pending result drain, then give the sequencer time to go idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (carousel.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write: setup, then access with penable
    task automatic write_tray_steps(input logic [SPT_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_TRAY_STEPS;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        carousel.spt = value;
    endtask

    // mostly well-formed traffic: ticks while a move runs, commands while idle,
    // with a share of bad values, busy commands and unused codes mixed in
    task automatic random_request(output bit counted);
        int                      pick;
        logic [2:0]              req;
        logic signed [VAL_W-1:0] val;
        pick = $urandom_range(0, 99);
        // -1 .. 9, wrapping into the 5-bit field
        val  = VAL_W'($urandom_range(0, 10) - 1);
        if (carousel.in_motion) begin
            if (pick < 85) begin
                req = REQ_TICK;
            end else begin
                req = 3'($urandom_range(0, 7));
                val = VAL_W'($urandom);
            end
        end else begin
            if ($urandom_range(0, 9) == 0)
                val = VAL_W'($urandom);
            if (pick < 40)
                req = REQ_SEEK;
            else if (pick < 60)
                req = REQ_WRITE;
            else if (pick < 72)
                req = REQ_NEXT;
            else if (pick < 84)
                req = REQ_PREV;
            else if (pick < 90)
                req = REQ_TICK;
            else
                req = 3'($urandom_range(5, 7));
        end
        // unused codes are rejected by the block and not counted
        counted = (req <= REQ_PREV);
        send_request(req, val);
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct,
                                input logic [SPT_W-1:0] spt);
        int count;
        bit counted;
        settle();
        write_tray_steps(spt);
        send_hold_pct = send_pct;
        recv_hold_pct = recv_pct;
        count = 0;
        while (count < PHASE_REQUESTS) begin
            random_request(counted);
            if (counted)
                count++;
        end
        finish_move();
    endtask

    initial begin
        send_hold_pct = 25;
        recv_hold_pct = 87;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_req_type    <= REQ_TICK;
        i_digit_value <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= ADDR_TRAY_STEPS;
        pwdata        <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // at reset steps: digit already under the head gives a zero-step move
        send_request(REQ_SEEK, 0);
        send_request(REQ_SEEK, 5);      // rejected, still moving
        send_request(REQ_TICK, 0);      // completes the zero-step move
        settle();
        write_tray_steps(12'd1);

        // rejections while idle
        send_request(REQ_SEEK, -1);     // no empty tray in the reset layout
        send_request(REQ_SEEK, 10);
        send_request(REQ_SEEK, -16);
        send_request(REQ_SEEK, 15);
        send_request(REQ_WRITE, 12);
        send_request(REQ_WRITE, -2);
        send_request(REQ_TICK, -1);     // idle tick does nothing
        send_request(3'd5, 0);
        send_request(3'd6, 9);
        send_request(3'd7, -1);

        // nearest 3 is clockwise; commands while busy are turned away
        send_request(REQ_SEEK, 3);
        send_request(REQ_WRITE, 1);
        send_request(REQ_NEXT, 0);
        send_request(REQ_PREV, 0);
        finish_move();
        // step to tray 8, then 9 sits half way round: tie goes clockwise
        send_request(REQ_NEXT, 0);
        finish_move();
        send_request(REQ_SEEK, 9);
        finish_move();
        send_request(REQ_PREV, 0);
        finish_move();
        // empty the current tray and seek the empty one in place
        send_request(REQ_WRITE, -1);
        send_request(REQ_SEEK, -1);
        finish_move();
        send_request(REQ_WRITE, 9);

        // random phases, receiver-heavy gaps, then sender-heavy, then none
        random_phase(25, 87, 12'd1);
        random_phase(87, 25, 12'($urandom_range(2, 4)));
        random_phase(0, 0, 12'($urandom_range(1, 3)));

        // widest step setting on a single one-tray move, left running at the end
        settle();
        write_tray_steps(12'd4095);
        send_request(REQ_NEXT, 0);
        send_request(REQ_SEEK, 0);

        settle();
        if (carousel.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
